FILE: rtl/ppj_pkg.sv
// Shared types, widths, codes and the divider step for the 3x4 projection block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ppj_pkg;

	localparam int COEF_W = 32;
	localparam int ACC_W  = 66;
	localparam int MAG_W  = 64;
	localparam int Q_W    = 32;
	localparam int STEPS  = 32;
	localparam int NREGS  = 6;
	localparam int IDX_W  = 3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_WZERO = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	// matrix entries, [row][col]
	typedef logic [2:0][3:0][COEF_W-1:0] mat_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ACC_W-1:0] w;
	} sum_t;

	typedef struct packed {
		logic [MAG_W-1:0] ru;
		logic [MAG_W-1:0] rv;
		logic [Q_W-1:0]   qu;
		logic [Q_W-1:0]   qv;
		logic [Q_W-1:0]   fu;
		logic [Q_W-1:0]   fv;
		logic [MAG_W-1:0] d;
		logic             negu;
		logic             negv;
		logic             satu;
		logic             satv;
		logic             zero;
	} div_t;

	typedef struct packed {
		logic [Q_W:0] qu;
		logic [Q_W:0] qv;
		logic         negu;
		logic         negv;
		logic         satu;
		logic         satv;
		logic         zero;
	} res_t;

	// one restoring step: bring in the next numerator bit, subtract if it fits
	function automatic div_t div_step(input div_t a);
		div_t         b;
		logic [MAG_W:0] r2u;
		logic [MAG_W:0] r2v;
		logic         geu;
		logic         gev;
		b   = a;
		r2u = {a.ru, a.fu[Q_W-1]};
		r2v = {a.rv, a.fv[Q_W-1]};
		geu = r2u >= {1'b0, a.d};
		gev = r2v >= {1'b0, a.d};
		b.ru = geu ? MAG_W'(r2u - {1'b0, a.d}) : r2u[MAG_W-1:0];
		b.rv = gev ? MAG_W'(r2v - {1'b0, a.d}) : r2v[MAG_W-1:0];
		b.qu = {a.qu[Q_W-2:0], geu};
		b.qv = {a.qv[Q_W-2:0], gev};
		b.fu = {a.fu[Q_W-2:0], 1'b0};
		b.fv = {a.fv[Q_W-2:0], 1'b0};
		return b;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/perspective_projection_3x4_top.sv
// Top level of the 3x4 perspective projection: config registers, pipeline, output stage.
// Depends on ppj_pkg, ppj_dot, ppj_prep and ppj_div.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one 64-bit
//    register per word; cfg_ready is always high, indexes above 5 are dropped.
//    Each register holds two signed Q16.16 entries, low half first.
//  - Input channel takes one point (point_x/y/z, Q16.16) per word, one per
//    cycle sustained while the receiver takes words. Output channel gives
//    image_u, image_v and status.
//  - The path is 38 register stages: two for the multiply and sum, two for
//    magnitudes and overflow check, 32 divider stages (one quotient bit each),
//    one rounding stage, one output register.
//  - Every stage has its own valid bit and moves when it is empty or the next
//    one moves, so a stalled receiver only backs up full stages; bubbles are
//    squeezed out and input is still taken while the output waits.
//  - Reset clears all valid bits and the matrix registers to zero.
//  - Write config only while no words are in flight.
`default_nettype none
module perspective_projection_3x4_top import ppj_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [63:0]              cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [COEF_W-1:0] point_x,
	input  wire logic signed [COEF_W-1:0] point_y,
	input  wire logic signed [COEF_W-1:0] point_z,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [Q_W-1:0]         image_u,
	output logic signed [Q_W-1:0]         image_v,
	output logic [1:0]                    status
);

	logic [63:0] regs_q [NREGS];
	mat_t        mat;
	sum_t        sums;
	div_t        seed;
	res_t        res;
	logic        dot_v, dot_r, prep_v, prep_r, div_v, div_r, adv_o;
	logic        satu, satv;
	logic        out_v_q;
	logic signed [Q_W-1:0] u_q, v_q;
	logic [1:0]  st_q;

	assign cfg_ready = 1'b1;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) regs_q[i] <= '0;
		end else if (cfg_valid && cfg_ready && cfg_index < IDX_W'(NREGS)) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			mat[r][0] = regs_q[2*r][31:0];
			mat[r][1] = regs_q[2*r][63:32];
			mat[r][2] = regs_q[2*r+1][31:0];
			mat[r][3] = regs_q[2*r+1][63:32];
		end
	end

	ppj_dot u_dot (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.px(point_x), .py(point_y), .pz(point_z), .mat(mat),
		.out_valid(dot_v), .out_ready(dot_r), .sums(sums)
	);

	ppj_prep u_prep (
		.clk(clk), .arst_n(arst_n),
		.in_valid(dot_v), .in_ready(dot_r), .sums(sums),
		.out_valid(prep_v), .out_ready(prep_r), .seed(seed)
	);

	ppj_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(prep_v), .in_ready(prep_r), .seed(seed),
		.out_valid(div_v), .out_ready(div_r), .res(res)
	);

	// output stage: saturate, apply sign, encode status
	assign adv_o = !out_v_q || out_ready;
	assign div_r = adv_o;
	assign satu  = res.satu || res.qu > {1'b0, res.negu ? 32'h8000_0000 : 32'h7FFF_FFFF};
	assign satv  = res.satv || res.qv > {1'b0, res.negv ? 32'h8000_0000 : 32'h7FFF_FFFF};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_o) begin
			out_v_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o && div_v) begin
			if (res.zero) begin
				u_q  <= '0;
				v_q  <= '0;
				st_q <= ST_WZERO;
			end else begin
				if (satu) u_q <= res.negu ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				else      u_q <= res.negu ? -$signed(res.qu[Q_W-1:0]) : $signed(res.qu[Q_W-1:0]);
				if (satv) v_q <= res.negv ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				else      v_q <= res.negv ? -$signed(res.qv[Q_W-1:0]) : $signed(res.qv[Q_W-1:0]);
				st_q <= (satu || satv) ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid = out_v_q;
	assign image_u   = u_q;
	assign image_v   = v_q;
	assign status    = st_q;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_WZERO || status == ST_SAT))
		else $error("unknown status code");

	a_wzero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_WZERO |-> image_u == '0 && image_v == '0)
		else $error("zero w result not cleared");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |->
			(image_u == 32'sh7FFF_FFFF || image_u == 32'sh8000_0000 ||
			 image_v == 32'sh7FFF_FFFF || image_v == 32'sh8000_0000))
		else $error("saturation flagged without a limit value");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule
`default_nettype wire

FILE: rtl/ppj_dot.sv
// Two-stage affine dot products x, y, w of the matrix rows with (X,Y,Z,1).
// Depends on ppj_pkg.
`default_nettype none
module ppj_dot import ppj_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [COEF_W-1:0] px,
	input  wire logic signed [COEF_W-1:0] py,
	input  wire logic signed [COEF_W-1:0] pz,
	input  wire mat_t                     mat,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output sum_t                          sums
);

	logic signed [COEF_W-1:0]   pt [3];
	logic signed [2*COEF_W-1:0] prod_d [3][3];
	logic signed [2*COEF_W-1:0] prod_s1 [3][3];
	logic signed [ACC_W-1:0]    row_d [3];
	sum_t                       sum_s2;
	logic                       v_s1, v_s2, adv1, adv2;

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// stage 1: nine products, Q32.32
	always_comb begin
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_d[r][c] = $signed(mat[r][c]) * pt[c];
			end
		end
	end

	// stage 2: exact sums with the constant column scaled to Q32.32
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_d[r] = $signed({{(ACC_W-COEF_W-16){mat[r][3][COEF_W-1]}}, mat[r][3], 16'h0})
				+ $signed({{2{prod_s1[r][0][2*COEF_W-1]}}, prod_s1[r][0]})
				+ $signed({{2{prod_s1[r][1][2*COEF_W-1]}}, prod_s1[r][1]})
				+ $signed({{2{prod_s1[r][2][2*COEF_W-1]}}, prod_s1[r][2]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) prod_s1 <= prod_d;
		if (adv2 && v_s1) begin
			sum_s2.x <= row_d[0];
			sum_s2.y <= row_d[1];
			sum_s2.w <= row_d[2];
		end
	end

	assign out_valid = v_s2;
	assign sums      = sum_s2;

endmodule
`default_nettype wire

FILE: rtl/ppj_prep.sv
// Magnitudes, signs, zero-w and early overflow check; seeds the divider.
// Depends on ppj_pkg.
`default_nettype none
module ppj_prep import ppj_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sum_t sums,
	output logic      out_valid,
	input  wire logic out_ready,
	output div_t      seed
);

	logic [MAG_W-1:0] xm_s3, ym_s3, wm_s3;
	logic             xn_s3, yn_s3, wn_s3;
	div_t             seed_s4, seed_d;
	logic             v_s3, v_s4, adv3, adv4;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign in_ready = adv3;

	function automatic logic [MAG_W-1:0] mag(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-1:0] m;
		m = a[ACC_W-1] ? (~a + ACC_W'(1)) : a;
		return m[MAG_W-1:0];
	endfunction

	// quotient of 2^32 or more saturates; else the top 48 bits seed the remainder
	always_comb begin
		seed_d      = '0;
		seed_d.d    = wm_s3;
		seed_d.zero = wm_s3 == '0;
		seed_d.negu = xn_s3 ^ wn_s3;
		seed_d.negv = yn_s3 ^ wn_s3;
		seed_d.satu = {16'h0, xm_s3} >= {wm_s3, 16'h0};
		seed_d.satv = {16'h0, ym_s3} >= {wm_s3, 16'h0};
		seed_d.ru   = {16'h0, xm_s3[MAG_W-1:16]};
		seed_d.rv   = {16'h0, ym_s3[MAG_W-1:16]};
		seed_d.fu   = {xm_s3[15:0], 16'h0};
		seed_d.fv   = {ym_s3[15:0], 16'h0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv3) v_s3 <= in_valid;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && in_valid) begin
			xm_s3 <= mag(sums.x);
			ym_s3 <= mag(sums.y);
			wm_s3 <= mag(sums.w);
			xn_s3 <= sums.x[ACC_W-1];
			yn_s3 <= sums.y[ACC_W-1];
			wn_s3 <= sums.w[ACC_W-1];
		end
		if (adv4 && v_s3) seed_s4 <= seed_d;
	end

	assign out_valid = v_s4;
	assign seed      = seed_s4;

endmodule
`default_nettype wire

FILE: rtl/ppj_div.sv
// Pipelined restoring divider for u and v, one quotient bit per stage, then rounding.
// Depends on ppj_pkg.
`default_nettype none
module ppj_div import ppj_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire div_t seed,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      res
);

	div_t         data_s [STEPS];
	res_t         res_s;
	logic [STEPS:0] vld_s;
	logic [STEPS:0] adv;
	logic         rbu, rbv;
	div_t         last;

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv[STEPS] = !vld_s[STEPS] || out_ready;
		for (int k = STEPS - 1; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end
	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= in_valid;
			for (int k = 1; k <= STEPS; k++) begin
				if (adv[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// divider steps
	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) data_s[0] <= div_step(seed);
		for (int k = 1; k < STEPS; k++) begin
			if (adv[k] && vld_s[k-1]) data_s[k] <= div_step(data_s[k-1]);
		end
	end

	// round to nearest, ties away from zero: bump when 2*rem >= d
	assign last = data_s[STEPS-1];
	assign rbu  = {last.ru, 1'b0} >= {1'b0, last.d};
	assign rbv  = {last.rv, 1'b0} >= {1'b0, last.d};

	always_ff @(posedge clk) begin
		if (adv[STEPS] && vld_s[STEPS-1]) begin
			res_s.qu   <= {1'b0, last.qu} + (Q_W+1)'(rbu);
			res_s.qv   <= {1'b0, last.qv} + (Q_W+1)'(rbv);
			res_s.negu <= last.negu;
			res_s.negv <= last.negv;
			res_s.satu <= last.satu;
			res_s.satv <= last.satv;
			res_s.zero <= last.zero;
		end
	end

	assign out_valid = vld_s[STEPS];
	assign res       = res_s;

endmodule
`default_nettype wire

FILE: tb/sv/perspective_projection_3x4_top_tb.sv
// Testbench for perspective_projection_3x4_top: directed table, then random points
// under several matrices, checked against an in-bench projection predictor.
// Depends on ppj_pkg and the RTL of the block.
`default_nettype none
module perspective_projection_3x4_top_tb;
	import ppj_pkg::*;

	localparam int CLK_HALF   = 4;
	localparam int CYC_LIMIT  = 400000;
	localparam int DRAIN_CYC  = 60;
	localparam int HOLD_CYC   = 300;

	// register indexes
	localparam logic [IDX_W-1:0] REG_R0_A  = 3'd0;
	localparam logic [IDX_W-1:0] REG_R0_B  = 3'd1;
	localparam logic [IDX_W-1:0] REG_R1_A  = 3'd2;
	localparam logic [IDX_W-1:0] REG_R1_B  = 3'd3;
	localparam logic [IDX_W-1:0] REG_R2_A  = 3'd4;
	localparam logic [IDX_W-1:0] REG_R2_B  = 3'd5;
	localparam logic [IDX_W-1:0] REG_NONE6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_NONE7 = 3'd7;

	localparam logic [31:0] ONE_Q = 32'h0001_0000;

	typedef struct {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic [1:0]         st;
	} pix_t;

	typedef struct {
		bit                 ident;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		bit                 typed;
		pix_t               exp;
	} row_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [31:0] point_x, point_y, point_z;
	logic out_valid, out_ready;
	logic signed [31:0] image_u, image_v;
	logic [1:0] status;

	// shadow of the matrix registers
	logic [63:0] mat_regs [NREGS];
	pix_t pending_pix [$];
	int   fails;
	int   cycles;
	int   idle_mode;     // 0: sender 25/rx 77, 1: swapped, 2: none
	bit   hold_req;
	int   hold_left;

	perspective_projection_3x4_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.image_u(image_u), .image_v(image_v), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// matrix entry [row][col] from the shadow registers
	function automatic logic signed [31:0] entry(input int r, input int c);
		logic [63:0] w;
		w = mat_regs[r * 2 + c / 2];
		return (c % 2) ? w[63:32] : w[31:0];
	endfunction

	// exact affine row sum in Q32.32
	function automatic logic signed [127:0] row_sum(input int r,
			input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] pz);
		logic signed [127:0] acc;
		longint prod;
		acc  = 128'sd0;
		prod = longint'(entry(r, 0)) * longint'(px);
		acc  = acc + prod;
		prod = longint'(entry(r, 1)) * longint'(py);
		acc  = acc + prod;
		prod = longint'(entry(r, 2)) * longint'(pz);
		acc  = acc + prod;
		prod = longint'(entry(r, 3)) * 64'sd65536;
		acc  = acc + prod;
		return acc;
	endfunction

	// rounded, saturated Q16.16 quotient of num/den
	function automatic logic [31:0] q16_div(input logic signed [127:0] num,
			input logic [127:0] dmag, input bit dneg, inout bit sat);
		logic [127:0] n, q, r, lim;
		bit neg;
		neg = (num < 0) != dneg;
		n   = (num < 0) ? -num : num;
		n   = n << 16;
		q   = n / dmag;
		r   = n % dmag;
		if (r >= dmag - r)
			q = q + 1;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim) begin
			sat = 1'b1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return neg ? 32'(-q) : q[31:0];
	endfunction

	function automatic pix_t project_point(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		pix_t p;
		logic signed [127:0] sx, sy, sw;
		logic [127:0] wm;
		bit sat;
		sx  = row_sum(0, px, py, pz);
		sy  = row_sum(1, px, py, pz);
		sw  = row_sum(2, px, py, pz);
		sat = 1'b0;
		if (sw == 0) begin
			p.u = 0; p.v = 0; p.st = ST_WZERO;
			return p;
		end
		wm  = (sw < 0) ? -sw : sw;
		p.u = q16_div(sx, wm, sw < 0, sat);
		p.v = q16_div(sy, wm, sw < 0, sat);
		p.st = sat ? ST_SAT : ST_OK;
		return p;
	endfunction

	// sender idles in this many cycles of a hundred
	function automatic bit tx_idle();
		int pct;
		pct = (idle_mode == 0) ? 25 : (idle_mode == 1) ? 77 : 0;
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(4, 0))
			0: rand_val = $urandom_range(1 << 19, 0) - (1 << 18);
			1: rand_val = ONE_Q * ($urandom_range(16, 0) - 8);
			2: begin
				case ($urandom_range(3, 0))
					0: rand_val = 32'h8000_0000;
					1: rand_val = 32'h7FFF_FFFF;
					2: rand_val = 32'h0;
					default: rand_val = 32'hFFFF_FFFF;
				endcase
			end
			default: rand_val = $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NREGS)
			mat_regs[idx] = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for the pipe to drain before touching the matrix
	task automatic wait_idle();
		while (pending_pix.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// offer one point; the expectation is queued at the accepting edge
	task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] pz, input bit typed, input pix_t exp);
		while (tx_idle()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= px;
		point_y  <= py;
		point_z  <= pz;
		do @(posedge clk); while (!in_ready);
		pending_pix.insert(pending_pix.size(), typed ? exp : project_point(px, py, pz));
		@(negedge clk);
	endtask

	task automatic random_matrix(input int flavor);
		int i;
		logic [63:0] d;
		for (i = 0; i < NREGS; i++) begin
			case (flavor)
				1: d = {2{32'h7FFF_FFFF}};
				2: d = {2{32'h8000_0000}};
				default: d = {rand_val(), rand_val()};
			endcase
			// keep the w row usually well away from zero
			if (flavor == 0 && i == REG_R2_B)
				d[63:32] = ONE_Q * $urandom_range(8, 1);
			write_reg(i[IDX_W-1:0], d);
		end
		write_reg(REG_NONE6, {$urandom, $urandom});
		write_reg(REG_NONE7, {$urandom, $urandom});
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("perspective_projection_3x4_top test failed");
			$finish;
		end
	end

	// receiver ready, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_left == 0)
			hold_left <= HOLD_CYC;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
		if (hold_left > 0)
			out_ready <= 1'b0;
		else if (idle_mode == 0)
			out_ready <= $urandom_range(99, 0) >= 77;
		else if (idle_mode == 1)
			out_ready <= $urandom_range(99, 0) >= 25;
		else
			out_ready <= 1'b1;
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin
		pix_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pix.size() == 0) begin
				$error("unexpected word u=%h v=%h status=%0d", image_u, image_v, status);
				fails++;
			end else begin
				e = pending_pix.pop_front();
				if (image_u !== e.u) begin
					$error("image_u expected %h actual %h", e.u, image_u);
					fails++;
				end
				if (image_v !== e.v) begin
					$error("image_v expected %h actual %h", e.v, image_v);
					fails++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					fails++;
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		pix_t none;
		int i, n, ph;
		bit cur_ident;

		fails = 0; cycles = 0; idle_mode = 0;
		hold_req = 1'b0; hold_left = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; point_x = '0; point_y = '0; point_z = '0;
		out_ready = 1'b0;
		for (i = 0; i < NREGS; i++)
			mat_regs[i] = 64'h0;
		none = '{0, 0, ST_OK};

		// directed table: zero matrix after reset, then identity
		rows.insert(rows.size(), '{0, 32'h0, 32'h0, 32'h0, 1, '{0, 0, ST_WZERO}});
		rows.insert(rows.size(), '{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
			'{0, 0, ST_WZERO}});
		rows.insert(rows.size(), '{1, 32'h2_0000, 32'h3_0000, ONE_Q, 1,
			'{32'h2_0000, 32'h3_0000, ST_OK}});
		rows.insert(rows.size(), '{1, 32'h5_0000, 32'hFFFF_0000, 32'h0, 1,
			'{0, 0, ST_WZERO}});
		rows.insert(rows.size(), '{1, 32'h7FFF_FFFF, 32'h0, 32'h1, 1,
			'{32'h7FFF_FFFF, 0, ST_SAT}});
		rows.insert(rows.size(), '{1, 32'h8000_0000, 32'h0, 32'h1, 1,
			'{32'h8000_0000, 0, ST_SAT}});
		rows.insert(rows.size(), '{1, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
			'{0, 32'h8000_0000, ST_SAT}});
		rows.insert(rows.size(), '{1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
			'{ONE_Q, ONE_Q, ST_OK}});
		rows.insert(rows.size(), '{1, 32'h1, 32'hFFFF_FFFF, 32'h2_0000, 0, none});  // ties
		rows.insert(rows.size(), '{1, 32'h1, 32'hFFFF_FFFF, 32'h3, 0, none});
		rows.insert(rows.size(), '{1, 32'hFFFF_FFFD, 32'h7, 32'h2, 0, none});
		rows.insert(rows.size(), '{1, 32'h0, 32'h0, 32'hFFFF_0000, 0, none});
		rows.insert(rows.size(), '{1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none});
		rows.insert(rows.size(), '{1, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_0100, 0, none});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cur_ident = 1'b0;
		foreach (rows[k]) begin
			rw = rows[k];
			if (rw.ident && !cur_ident) begin
				in_valid <= 1'b0;
				wait_idle();
				write_reg(REG_R0_A, {32'h0, ONE_Q});
				write_reg(REG_R0_B, 64'h0);
				write_reg(REG_R1_A, {ONE_Q, 32'h0});
				write_reg(REG_R1_B, 64'h0);
				write_reg(REG_R2_A, 64'h0);
				write_reg(REG_R2_B, {32'h0, ONE_Q});
				cur_ident = 1'b1;
			end
			send_point(rw.x, rw.y, rw.z, rw.typed, rw.exp);
		end

		// random phases under several matrices, extremes included
		n = 0;
		for (ph = 0; ph < 8; ph++) begin
			in_valid <= 1'b0;
			wait_idle();
			random_matrix(ph == 2 ? 1 : ph == 5 ? 2 : 0);
			for (i = 0; i < 140; i++) begin
				idle_mode = (n < 370) ? 0 : (n < 740) ? 1 : 2;
				if (n == 800)
					hold_req = 1'b1;
				if (n == 820)
					hold_req = 1'b0;
				if (n == 500) begin
					in_valid <= 1'b0;
					do @(negedge clk); while (pending_pix.size() != 0);
				end
				send_point(rand_val(), rand_val(), rand_val(), 0, none);
				n++;
			end
		end
		in_valid <= 1'b0;

		while (pending_pix.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fails == 0)
			$display("perspective_projection_3x4_top test passed");
		else
			$display("perspective_projection_3x4_top test failed");
		$finish;
	end

endmodule
`default_nettype wire
